// ===== src/wpp_pkg.sv =====
`default_nettype none

package wpp_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_VIEWER_X     = 3'd0,
        CFG_VIEWER_Y     = 3'd1,
        CFG_VIEWER_Z     = 3'd2,
        CFG_VIEWER_ANGLE = 3'd3,
        CFG_LOOK_PITCH   = 3'd4,
        CFG_HALF_WIDTH   = 3'd5,
        CFG_HALF_HEIGHT  = 3'd6
    } t_cfg_idx;

    localparam int PROJ_SCALE_DEF = 200;

    // datapath widths
    localparam int ROT_W      = 19;  // rotated x and depth
    localparam int CORNER_W   = 24;  // corner values after height offset
    localparam int CLIP_DEN_W = 19;
    localparam int CLIP_Q_W   = 16;  // clip factor, Q0.16
    localparam int CLIP_NUM_W = CLIP_DEN_W + CLIP_Q_W;
    localparam int PROJ_DEN_W = 19;
    localparam int PROJ_Q_W   = 18;
    localparam int PROJ_NUM_W = PROJ_DEN_W + PROJ_Q_W;
    localparam int ROOT_W     = 18;
    localparam int RAD_W      = 2 * ROOT_W;

    // corner slots
    localparam int C_X   = 0;
    localparam int C_D   = 1;
    localparam int C_BOT = 2;
    localparam int C_TOP = 3;

    typedef logic [3:0][CORNER_W-1:0] t_corner;

    // side data travelling with the clip divider
    typedef struct packed {
        logic    culled;
        logic    clip_a;
        logic    clip_b;
        t_corner near_c;
        t_corner far_c;
    } t_clip;

    // side data travelling with the projection dividers
    typedef struct packed {
        logic              culled;
        logic [5:0]        neg;
        logic [5:0]        ovf;
        logic [ROOT_W-1:0] mid;
    } t_pside;

    // first quadrant of the Q1.14 sine, whole degrees
    localparam logic [14:0] QSINE [91] = '{
        15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
        15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
        15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
        15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
        15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
        15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
        15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
        15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849,
        15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491,
        15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
        15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // full-circle sine from the quarter table, angle 0..359
    function automatic logic signed [15:0] sine_q14(input logic [8:0] ang);
        logic [8:0] q;
        logic       neg;
        if (ang <= 9'd90) begin
            q = ang;
            neg = 1'b0;
        end else if (ang <= 9'd180) begin
            q = 9'd180 - ang;
            neg = 1'b0;
        end else if (ang <= 9'd270) begin
            q = ang - 9'd180;
            neg = 1'b1;
        end else begin
            q = 9'd360 - ang;
            neg = 1'b1;
        end
        if (neg) begin
            return -$signed({1'b0, QSINE[q[6:0]]});
        end
        return $signed({1'b0, QSINE[q[6:0]]});
    endfunction

    // divide by 16384, rounding toward zero
    function automatic logic signed [ROT_W-1:0] trunc_q14(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = v + (v[33] ? 34'sd16383 : 34'sd0);
        return ROT_W'(t >>> 14);
    endfunction

    // divide by 2, rounding toward zero
    function automatic logic signed [ROT_W-1:0] trunc_half(input logic signed [19:0] v);
        logic signed [19:0] t;
        t = v + (v[19] ? 20'sd1 : 20'sd0);
        return ROT_W'(t >>> 1);
    endfunction

    // divide by 32, rounding toward zero
    function automatic logic signed [CORNER_W-1:0] trunc_d32(input logic signed [27:0] v);
        logic signed [27:0] t;
        t = v + (v[27] ? 28'sd31 : 28'sd0);
        return CORNER_W'(t >>> 5);
    endfunction

    // divide by 65536, rounding toward zero
    function automatic logic signed [CORNER_W-1:0] trunc_q16(input logic signed [41:0] v);
        logic signed [41:0] t;
        t = v + (v[41] ? 42'sd65535 : 42'sd0);
        return CORNER_W'(t >>> 16);
    endfunction

    // clamp to 16 bit signed
    function automatic logic [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'h7fff;
        end else if (v < -20'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/wpp_div.sv =====
`default_nettype none

// unsigned restoring divider, one quotient bit per stage
// the quotient must fit Q_W bits (num < den << Q_W)
module wpp_div #(
    parameter int DEN_W = 19,
    parameter int Q_W   = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [DEN_W+Q_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]       i_den,
    output logic      [Q_W-1:0]         o_quot
);

    localparam int NUM_W = DEN_W + Q_W;

    logic [NUM_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_stage
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [Q_W-1:0]   q_in;
            logic [NUM_W:0]   trial;

            if (k == 0) begin : g_first
                assign rem_in = i_num;
                assign den_in = i_den;
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign den_in = r_den[k-1];
                assign q_in   = r_q[k-1];
            end

            // trial subtract of the shifted divisor
            assign trial = {1'b0, rem_in} - ((NUM_W+1)'(den_in) << (Q_W - 1 - k));

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= den_in;
                    if (trial[NUM_W]) begin
                        r_rem[k] <= rem_in;
                        r_q[k]   <= q_in;
                    end else begin
                        r_rem[k] <= trial[NUM_W-1:0];
                        r_q[k]   <= q_in | (Q_W'(1) << (Q_W - 1 - k));
                    end
                end
            end
        end
    endgenerate

    assign o_quot = r_q[Q_W-1];

endmodule

`default_nettype wire

// ===== src/wall_perspective_projector_unit.sv =====
`default_nettype none

// channel    direction  handshake            payload
// -------    ---------  -------------------  ------------------------------------------
// wall       in         i_valid / o_ready    end points, floor and wall height, reverse
// result     out        o_valid / i_ready    culled, columns, rows, mid distance
// config     in         i_cfg_we             i_cfg_addr, i_cfg_wdata
//
// one wall per cycle while the pipeline is not held; every result passes through the
// 16 stage clip divider and the 18 stage projection dividers in series.
// the whole pipeline holds when a result waits at the output and i_ready is low.
// synchronous active low reset clears the valid bits, viewer position, angle and pitch.
module wall_perspective_projector_unit #(
    parameter int PROJ_SCALE = wpp_pkg::PROJ_SCALE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_addr,
    input  wire logic [15:0]        i_cfg_wdata,
    // wall requests
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_end_a_x,
    input  wire logic signed [15:0] i_end_a_y,
    input  wire logic signed [15:0] i_end_b_x,
    input  wire logic signed [15:0] i_end_b_y,
    input  wire logic signed [15:0] i_floor_height,
    input  wire logic [14:0]        i_wall_height,
    input  wire logic               i_reverse,
    // results
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_culled,
    output logic signed [15:0]      o_left_column,
    output logic signed [15:0]      o_right_column,
    output logic signed [15:0]      o_bottom_row_a,
    output logic signed [15:0]      o_bottom_row_b,
    output logic signed [15:0]      o_top_row_a,
    output logic signed [15:0]      o_top_row_b,
    output logic [17:0]             o_mid_distance
);

    localparam int ROT_W      = wpp_pkg::ROT_W;
    localparam int CORNER_W   = wpp_pkg::CORNER_W;
    localparam int CLIP_Q_W   = wpp_pkg::CLIP_Q_W;
    localparam int CLIP_DEN_W = wpp_pkg::CLIP_DEN_W;
    localparam int CLIP_NUM_W = wpp_pkg::CLIP_NUM_W;
    localparam int PROJ_Q_W   = wpp_pkg::PROJ_Q_W;
    localparam int PROJ_DEN_W = wpp_pkg::PROJ_DEN_W;
    localparam int PROJ_NUM_W = wpp_pkg::PROJ_NUM_W;
    localparam int ROOT_W     = wpp_pkg::ROOT_W;
    localparam int RAD_W      = wpp_pkg::RAD_W;
    localparam int SCALE_W    = $clog2(PROJ_SCALE + 1);
    localparam int PN_W       = CORNER_W + SCALE_W;
    localparam int LAT        = 5 + CLIP_Q_W + 4 + PROJ_Q_W + 1;

    localparam logic signed [PN_W-1:0] SCALE_S = PN_W'(PROJ_SCALE);

    // viewer registers
    logic signed [15:0] r_vx, r_vy, r_vz;
    logic [8:0]         r_angle;
    logic signed [7:0]  r_pitch;
    logic [10:0]        r_half_w, r_half_h;

    logic           en;
    logic [LAT-1:0] r_vld;

    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx     <= '0;
            r_vy     <= '0;
            r_vz     <= '0;
            r_angle  <= '0;
            r_pitch  <= '0;
            r_half_w <= 11'd320;
            r_half_h <= 11'd240;
        end else if (i_cfg_we) begin
            case (wpp_pkg::t_cfg_idx'(i_cfg_addr))
                wpp_pkg::CFG_VIEWER_X:     r_vx     <= i_cfg_wdata;
                wpp_pkg::CFG_VIEWER_Y:     r_vy     <= i_cfg_wdata;
                wpp_pkg::CFG_VIEWER_Z:     r_vz     <= i_cfg_wdata;
                wpp_pkg::CFG_VIEWER_ANGLE: r_angle  <= i_cfg_wdata[8:0];
                wpp_pkg::CFG_LOOK_PITCH:   r_pitch  <= i_cfg_wdata[7:0];
                wpp_pkg::CFG_HALF_WIDTH:   r_half_w <= i_cfg_wdata[10:0];
                wpp_pkg::CFG_HALF_HEIGHT:  r_half_h <= i_cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ---------------- stage 1: translate, swap, sine lookup ----------------
    logic [8:0]  ang_w, cos_idx;
    logic [9:0]  ang90;
    logic signed [16:0] dax, day, dbx, dby;

    assign ang_w   = (r_angle >= 9'd360) ? r_angle - 9'd360 : r_angle;
    assign ang90   = 10'(ang_w) + 10'd90;
    assign cos_idx = (ang90 >= 10'd360) ? 9'(ang90 - 10'd360) : ang90[8:0];
    assign dax     = 17'(i_end_a_x) - 17'(r_vx);
    assign day     = 17'(i_end_a_y) - 17'(r_vy);
    assign dbx     = 17'(i_end_b_x) - 17'(r_vx);
    assign dby     = 17'(i_end_b_y) - 17'(r_vy);

    logic signed [16:0] r1_ax, r1_ay, r1_bx, r1_by, r1_fz;
    logic signed [15:0] r1_sn, r1_cs;
    logic [14:0]        r1_wh;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ax <= i_reverse ? dbx : dax;
            r1_ay <= i_reverse ? dby : day;
            r1_bx <= i_reverse ? dax : dbx;
            r1_by <= i_reverse ? day : dby;
            r1_sn <= wpp_pkg::sine_q14(ang_w);
            r1_cs <= wpp_pkg::sine_q14(cos_idx);
            r1_fz <= 17'(i_floor_height) - 17'(r_vz);
            r1_wh <= i_wall_height;
        end
    end

    // ---------------- stage 2: rotation products ----------------
    logic signed [32:0] r2_p [8];
    logic signed [16:0] r2_fz;
    logic [14:0]        r2_wh;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p[0] <= 33'(r1_ax) * 33'(r1_cs);
            r2_p[1] <= 33'(r1_ay) * 33'(r1_sn);
            r2_p[2] <= 33'(r1_ay) * 33'(r1_cs);
            r2_p[3] <= 33'(r1_ax) * 33'(r1_sn);
            r2_p[4] <= 33'(r1_bx) * 33'(r1_cs);
            r2_p[5] <= 33'(r1_by) * 33'(r1_sn);
            r2_p[6] <= 33'(r1_by) * 33'(r1_cs);
            r2_p[7] <= 33'(r1_bx) * 33'(r1_sn);
            r2_fz   <= r1_fz;
            r2_wh   <= r1_wh;
        end
    end

    // ---------------- stage 3: rotated x and depth ----------------
    logic signed [ROT_W-1:0] r3_ax, r3_ad, r3_bx, r3_bd;
    logic signed [16:0]      r3_fz;
    logic [14:0]             r3_wh;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ax <= wpp_pkg::trunc_q14(34'(r2_p[0]) - 34'(r2_p[1]));
            r3_ad <= wpp_pkg::trunc_q14(34'(r2_p[2]) + 34'(r2_p[3]));
            r3_bx <= wpp_pkg::trunc_q14(34'(r2_p[4]) - 34'(r2_p[5]));
            r3_bd <= wpp_pkg::trunc_q14(34'(r2_p[6]) + 34'(r2_p[7]));
            r3_fz <= r2_fz;
            r3_wh <= r2_wh;
        end
    end

    // ---------------- stage 4: midpoint squares, pitch products ----------------
    logic signed [ROT_W-1:0] mid_x, mid_y;
    logic signed [37:0]      sq_x, sq_y;

    assign mid_x = wpp_pkg::trunc_half(20'(r3_ax) + 20'(r3_bx));
    assign mid_y = wpp_pkg::trunc_half(20'(r3_ad) + 20'(r3_bd));
    assign sq_x  = 38'(mid_x) * 38'(mid_x);
    assign sq_y  = 38'(mid_y) * 38'(mid_y);

    logic [RAD_W-1:0]        r4_sqx, r4_sqy;
    logic signed [26:0]      r4_lka, r4_lkb;
    logic signed [ROT_W-1:0] r4_ax, r4_ad, r4_bx, r4_bd;
    logic signed [16:0]      r4_fz;
    logic [14:0]             r4_wh;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sqx <= sq_x[RAD_W-1:0];
            r4_sqy <= sq_y[RAD_W-1:0];
            r4_lka <= 27'(r_pitch) * 27'(r3_ad);
            r4_lkb <= 27'(r_pitch) * 27'(r3_bd);
            r4_ax  <= r3_ax;
            r4_ad  <= r3_ad;
            r4_bx  <= r3_bx;
            r4_bd  <= r3_bd;
            r4_fz  <= r3_fz;
            r4_wh  <= r3_wh;
        end
    end

    // ---------------- stage 5: heights, cull, clip set-up ----------------
    logic signed [CORNER_W-1:0] hb_a, hb_b, ht_a, ht_b;
    logic signed [27:0]         fz32;
    wpp_pkg::t_corner           cor_a, cor_b;
    wpp_pkg::t_clip             n_clip;
    logic signed [ROT_W-1:0]    near_d, far_d, neg_d;
    logic signed [ROT_W:0]      den_s;
    logic [CLIP_NUM_W-1:0]      n_cnum;
    logic [CLIP_DEN_W-1:0]      n_cden;

    assign fz32 = 28'(r4_fz) <<< 5;
    assign hb_a = wpp_pkg::trunc_d32(fz32 + 28'(r4_lka));
    assign hb_b = wpp_pkg::trunc_d32(fz32 + 28'(r4_lkb));
    assign ht_a = hb_a + CORNER_W'(r4_wh);
    assign ht_b = hb_b + CORNER_W'(r4_wh);

    always_comb begin
        cor_a[wpp_pkg::C_X]   = CORNER_W'(r4_ax);
        cor_a[wpp_pkg::C_D]   = CORNER_W'(r4_ad);
        cor_a[wpp_pkg::C_BOT] = hb_a;
        cor_a[wpp_pkg::C_TOP] = ht_a;
        cor_b[wpp_pkg::C_X]   = CORNER_W'(r4_bx);
        cor_b[wpp_pkg::C_D]   = CORNER_W'(r4_bd);
        cor_b[wpp_pkg::C_BOT] = hb_b;
        cor_b[wpp_pkg::C_TOP] = ht_b;

        n_clip.culled = (r4_ad < ROT_W'(1)) && (r4_bd < ROT_W'(1));
        n_clip.clip_a = (r4_ad < ROT_W'(1)) && !n_clip.culled;
        n_clip.clip_b = (r4_bd < ROT_W'(1)) && !n_clip.culled && !n_clip.clip_a;
        // the endpoint behind the plane is the near one
        n_clip.near_c = n_clip.clip_b ? cor_b : cor_a;
        n_clip.far_c  = n_clip.clip_b ? cor_a : cor_b;

        near_d = n_clip.clip_b ? r4_bd : r4_ad;
        far_d  = n_clip.clip_b ? r4_ad : r4_bd;
        neg_d  = -near_d;
        den_s  = (ROT_W+1)'(far_d) - (ROT_W+1)'(near_d);
        if (n_clip.clip_a || n_clip.clip_b) begin
            n_cnum = CLIP_NUM_W'($unsigned(neg_d)) << 16;
            n_cden = den_s[CLIP_DEN_W-1:0];
        end else begin
            n_cnum = '0;
            n_cden = CLIP_DEN_W'(1);
        end
    end

    wpp_pkg::t_clip        r5_clip;
    logic [CLIP_NUM_W-1:0] r5_cnum;
    logic [CLIP_DEN_W-1:0] r5_cden;
    logic [RAD_W-1:0]      r5_rad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_clip <= n_clip;
            r5_cnum <= n_cnum;
            r5_cden <= n_cden;
            r5_rad  <= r4_sqx + r4_sqy;
        end
    end

    // ---------------- clip factor divider and its side data ----------------
    logic [CLIP_Q_W-1:0] clip_s;
    wpp_pkg::t_clip      r_cd [CLIP_Q_W];

    wpp_div #(
        .DEN_W (CLIP_DEN_W),
        .Q_W   (CLIP_Q_W)
    ) u_clip_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r5_cnum),
        .i_den  (r5_cden),
        .o_quot (clip_s)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cd[0] <= r5_clip;
            for (int i = 1; i < CLIP_Q_W; i++) begin
                r_cd[i] <= r_cd[i-1];
            end
        end
    end

    // ---------------- midpoint square root, one bit per stage ----------------
    logic [RAD_W-1:0]  r_sq_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_sq_root [ROOT_W];

    genvar j;
    generate
        for (j = 0; j < ROOT_W; j++) begin : g_sqrt
            localparam int B = ROOT_W - 1 - j;
            logic [RAD_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [RAD_W:0]    t;
            logic              ge;

            if (j == 0) begin : g_first
                assign rem_in  = r5_rad;
                assign root_in = '0;
            end else begin : g_next
                assign rem_in  = r_sq_rem[j-1];
                assign root_in = r_sq_root[j-1];
            end

            // (root + 2^b)^2 - root^2
            assign t  = ((RAD_W+1)'(root_in) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));
            assign ge = {1'b0, rem_in} >= t;

            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (ge) begin
                        r_sq_rem[j]  <= RAD_W'({1'b0, rem_in} - t);
                        r_sq_root[j] <= root_in | (ROOT_W'(1) << B);
                    end else begin
                        r_sq_rem[j]  <= rem_in;
                        r_sq_root[j] <= root_in;
                    end
                end
            end
        end
    endgenerate

    // ---------------- stage 22: clip interpolation products ----------------
    wpp_pkg::t_clip    c22;
    logic signed [41:0] n_lp [4];

    assign c22 = r_cd[CLIP_Q_W-1];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_lp[k] = 42'($signed({1'b0, clip_s}))
                    * 42'(25'($signed(c22.far_c[k])) - 25'($signed(c22.near_c[k])));
        end
    end

    logic signed [41:0] r22_lp [4];
    wpp_pkg::t_clip     r22_clip;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r22_lp   <= n_lp;
            r22_clip <= c22;
        end
    end

    // ---------------- stage 23: clipped corner, final endpoints ----------------
    wpp_pkg::t_corner clipped, n_cor_a, n_cor_b;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            clipped[k] = wpp_pkg::trunc_q16(
                (42'($signed(r22_clip.near_c[k])) <<< 16) + r22_lp[k]);
        end
        // a depth that lands on zero is forced to one
        if (clipped[wpp_pkg::C_D] == '0) begin
            clipped[wpp_pkg::C_D] = CORNER_W'(1);
        end
        if (r22_clip.clip_b) begin
            n_cor_a = r22_clip.far_c;
            n_cor_b = clipped;
        end else begin
            n_cor_a = r22_clip.clip_a ? clipped : r22_clip.near_c;
            n_cor_b = r22_clip.far_c;
        end
    end

    wpp_pkg::t_corner r23_a, r23_b;
    logic             r23_culled;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r23_a      <= n_cor_a;
            r23_b      <= n_cor_b;
            r23_culled <= r22_clip.culled;
        end
    end

    // ---------------- stage 24: projection numerators ----------------
    logic signed [PN_W-1:0]     r24_num [6];
    logic signed [CORNER_W-1:0] r24_dep_a, r24_dep_b;
    logic                       r24_culled;
    logic [ROOT_W-1:0]          r24_mid;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r24_num[0] <= PN_W'($signed(r23_a[wpp_pkg::C_X]))   * SCALE_S;
            r24_num[1] <= PN_W'($signed(r23_b[wpp_pkg::C_X]))   * SCALE_S;
            r24_num[2] <= PN_W'($signed(r23_a[wpp_pkg::C_BOT])) * SCALE_S;
            r24_num[3] <= PN_W'($signed(r23_b[wpp_pkg::C_BOT])) * SCALE_S;
            r24_num[4] <= PN_W'($signed(r23_a[wpp_pkg::C_TOP])) * SCALE_S;
            r24_num[5] <= PN_W'($signed(r23_b[wpp_pkg::C_TOP])) * SCALE_S;
            r24_dep_a  <= $signed(r23_a[wpp_pkg::C_D]);
            r24_dep_b  <= $signed(r23_b[wpp_pkg::C_D]);
            r24_culled <= r23_culled;
            r24_mid    <= r_sq_root[ROOT_W-1];
        end
    end

    // ---------------- stage 25: magnitudes and overflow test ----------------
    logic [PROJ_NUM_W-1:0] r25_num [6];
    logic [PROJ_DEN_W-1:0] r25_den [6];
    wpp_pkg::t_pside       r25_side;
    wpp_pkg::t_pside       n_side;
    logic [PROJ_NUM_W-1:0] n_pnum [6];
    logic [PROJ_DEN_W-1:0] n_pden [6];

    always_comb begin
        logic signed [CORNER_W-1:0] dep;
        logic signed [CORNER_W-1:0] dabs;
        logic signed [PN_W-1:0]     nabs;
        logic [PROJ_NUM_W-1:0]      mag;
        n_side.culled = r24_culled;
        n_side.mid    = r24_mid;
        for (int k = 0; k < 6; k++) begin
            dep  = k[0] ? r24_dep_b : r24_dep_a;
            dabs = dep[CORNER_W-1] ? -dep : dep;
            nabs = r24_num[k][PN_W-1] ? -r24_num[k] : r24_num[k];
            mag  = PROJ_NUM_W'($unsigned(nabs));
            n_pden[k]     = dabs[PROJ_DEN_W-1:0];
            n_side.neg[k] = r24_num[k][PN_W-1] ^ dep[CORNER_W-1];
            // quotient beyond the divider's bits saturates anyway
            n_side.ovf[k] = (mag >> PROJ_Q_W) >= PROJ_NUM_W'(n_pden[k]);
            n_pnum[k]     = n_side.ovf[k] ? '0 : mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r25_num  <= n_pnum;
            r25_den  <= n_pden;
            r25_side <= n_side;
        end
    end

    // ---------------- projection dividers and side data ----------------
    logic [PROJ_Q_W-1:0] proj_q [6];
    wpp_pkg::t_pside     r_pd [PROJ_Q_W];

    genvar p;
    generate
        for (p = 0; p < 6; p++) begin : g_proj
            wpp_div #(
                .DEN_W (PROJ_DEN_W),
                .Q_W   (PROJ_Q_W)
            ) u_proj_div (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_num  (r25_num[p]),
                .i_den  (r25_den[p]),
                .o_quot (proj_q[p])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pd[0] <= r25_side;
            for (int i = 1; i < PROJ_Q_W; i++) begin
                r_pd[i] <= r_pd[i-1];
            end
        end
    end

    // ---------------- output stage: sign, centre, saturate ----------------
    wpp_pkg::t_pside po;
    logic [15:0]     n_scr [6];

    assign po = r_pd[PROJ_Q_W-1];

    always_comb begin
        logic signed [19:0] sv;
        logic [10:0]        ctr;
        for (int k = 0; k < 6; k++) begin
            ctr = (k < 2) ? r_half_w : r_half_h;
            sv  = po.neg[k] ? -20'(proj_q[k]) : 20'(proj_q[k]);
            sv  = sv + 20'(ctr);
            if (po.culled) begin
                n_scr[k] = '0;
            end else if (po.ovf[k]) begin
                n_scr[k] = po.neg[k] ? 16'h8000 : 16'h7fff;
            end else begin
                n_scr[k] = wpp_pkg::sat16(sv);
            end
        end
    end

    logic [15:0]       r_scr [6];
    logic              r_culled;
    logic [ROOT_W-1:0] r_mid;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_scr    <= n_scr;
            r_culled <= po.culled;
            r_mid    <= po.mid;
        end
    end

    assign o_culled       = r_culled;
    assign o_left_column  = r_scr[0];
    assign o_right_column = r_scr[1];
    assign o_bottom_row_a = r_scr[2];
    assign o_bottom_row_b = r_scr[3];
    assign o_top_row_a    = r_scr[4];
    assign o_top_row_b    = r_scr[5];
    assign o_mid_distance = r_mid;

endmodule

`default_nettype wire

// ===== sim/tb_wall_perspective_projector_unit.sv =====
`default_nettype none

module tb_wall_perspective_projector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // one projected wall as it leaves the block
    typedef struct {
        bit      culled;
        longint  left_col;
        longint  right_col;
        longint  bot_a;
        longint  bot_b;
        longint  top_a;
        longint  top_b;
        longint  mid;
    } t_wall_view;

    // projection predictor and queue of pending screen results
    class wall_scoreboard;
        t_wall_view   pending[$];
        int           errors;
        logic [15:0]  vx, vy, vz;
        logic [8:0]   heading;
        logic [7:0]   pitch;
        logic [10:0]  half_w, half_h;

        function new();
            errors = 0;
            vx = '0; vy = '0; vz = '0; heading = '0; pitch = '0;
            half_w = 11'd320; half_h = 11'd240;
        endfunction

        function void set_reg(wpp_pkg::t_cfg_idx idx, logic [15:0] v);
            case (idx)
                wpp_pkg::CFG_VIEWER_X:     vx = v;
                wpp_pkg::CFG_VIEWER_Y:     vy = v;
                wpp_pkg::CFG_VIEWER_Z:     vz = v;
                wpp_pkg::CFG_VIEWER_ANGLE: heading = v[8:0];
                wpp_pkg::CFG_LOOK_PITCH:   pitch = v[7:0];
                wpp_pkg::CFG_HALF_WIDTH:   half_w = v[10:0];
                wpp_pkg::CFG_HALF_HEIGHT:  half_h = v[10:0];
                default: ;
            endcase
        endfunction

        function longint sine_deg(int a);
            a = a % 360;
            if (a <= 90) return wpp_pkg::QSINE[a];
            if (a <= 180) return wpp_pkg::QSINE[180 - a];
            if (a <= 270) return -longint'(wpp_pkg::QSINE[a - 180]);
            return -longint'(wpp_pkg::QSINE[360 - a]);
        endfunction

        function longint root_floor(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        // move corner p along the wall towards corner q, onto the near plane
        function void clip_corner(inout longint p[4], input longint q[4]);
            longint den, s;
            den = p[1] - q[1];
            if (den == 0) den = 1;
            s = (p[1] * 65536) / den;
            for (int i = 0; i < 4; i++) p[i] = (p[i] * 65536 + s * (q[i] - p[i])) / 65536;
            if (p[1] == 0) p[1] = 1;
        endfunction

        function longint to_screen(longint v, longint depth, longint centre);
            longint r;
            if (depth == 0) depth = 1;
            r = v * wpp_pkg::PROJ_SCALE_DEF / depth + centre;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r;
        endfunction

        function void note_wall(logic signed [15:0] ax_i, logic signed [15:0] ay_i,
                                logic signed [15:0] bx_i, logic signed [15:0] by_i,
                                logic signed [15:0] fh_i, logic [14:0] wh_i, bit rev);
            longint ax, ay, bx, by, t, cs, sn, fh, mx, my;
            longint pa[4], pb[4];
            int ang;
            t_wall_view w;
            ang = heading;
            if (ang >= 360) ang -= 360;
            sn = sine_deg(ang);
            cs = sine_deg(ang + 90);
            ax = longint'(ax_i) - longint'($signed(vx));
            ay = longint'(ay_i) - longint'($signed(vy));
            bx = longint'(bx_i) - longint'($signed(vx));
            by = longint'(by_i) - longint'($signed(vy));
            if (rev) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            pa[0] = (ax * cs - ay * sn) / 16384;
            pa[1] = (ay * cs + ax * sn) / 16384;
            pb[0] = (bx * cs - by * sn) / 16384;
            pb[1] = (by * cs + bx * sn) / 16384;
            mx = (pa[0] + pb[0]) / 2;
            my = (pa[1] + pb[1]) / 2;
            w.mid = root_floor(longint'(mx * mx) + longint'(my * my)) & 64'h3ffff;
            fh = longint'(fh_i) - longint'($signed(vz));
            pa[2] = (fh * 32 + longint'($signed(pitch)) * pa[1]) / 32;
            pb[2] = (fh * 32 + longint'($signed(pitch)) * pb[1]) / 32;
            pa[3] = pa[2] + longint'(wh_i);
            pb[3] = pb[2] + longint'(wh_i);
            if (pa[1] < 1 && pb[1] < 1) begin
                w.culled = 1'b1;
                w.left_col = 0; w.right_col = 0;
                w.bot_a = 0; w.bot_b = 0; w.top_a = 0; w.top_b = 0;
            end else begin
                if (pa[1] < 1) clip_corner(pa, pb);
                if (pb[1] < 1) clip_corner(pb, pa);
                w.culled    = 1'b0;
                w.left_col  = to_screen(pa[0], pa[1], half_w);
                w.right_col = to_screen(pb[0], pb[1], half_w);
                w.bot_a     = to_screen(pa[2], pa[1], half_h);
                w.bot_b     = to_screen(pb[2], pb[1], half_h);
                w.top_a     = to_screen(pa[3], pa[1], half_h);
                w.top_b     = to_screen(pb[3], pb[1], half_h);
            end
            pending.push_back(w);
        endfunction

        function void cmp(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_view(t_wall_view got);
            t_wall_view want;
            if (pending.size() == 0) begin
                errors++;
                $error("result with no request outstanding");
                return;
            end
            want = pending.pop_front();
            cmp("culled", want.culled, got.culled);
            cmp("left_column", want.left_col, got.left_col);
            cmp("right_column", want.right_col, got.right_col);
            cmp("bottom_row_a", want.bot_a, got.bot_a);
            cmp("bottom_row_b", want.bot_b, got.bot_b);
            cmp("top_row_a", want.top_a, got.top_a);
            cmp("top_row_b", want.top_b, got.top_b);
            cmp("mid_distance", want.mid, got.mid);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_addr = '0;
    logic [15:0]        i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_end_a_x = '0, i_end_a_y = '0, i_end_b_x = '0, i_end_b_y = '0;
    logic signed [15:0] i_floor_height = '0;
    logic [14:0]        i_wall_height = '0;
    logic               i_reverse = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_culled;
    logic signed [15:0] o_left_column, o_right_column;
    logic signed [15:0] o_bottom_row_a, o_bottom_row_b, o_top_row_a, o_top_row_b;
    logic [17:0]        o_mid_distance;

    bit             steady = 1'b0;
    wall_scoreboard sb = new();

    wall_perspective_projector_unit dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // accepted wall requests feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            sb.note_wall(i_end_a_x, i_end_a_y, i_end_b_x, i_end_b_y,
                         i_floor_height, i_wall_height, i_reverse);
    end

    // accepted results are checked in order
    always @(posedge i_clk) begin
        t_wall_view got;
        if (i_rst_n && o_valid && i_ready) begin
            got.culled = o_culled;
            got.left_col = o_left_column;
            got.right_col = o_right_column;
            got.bot_a = o_bottom_row_a;
            got.bot_b = o_bottom_row_b;
            got.top_a = o_top_row_a;
            got.top_b = o_top_row_b;
            got.mid = o_mid_distance;
            sb.check_view(got);
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 14);
    end

    task automatic write_reg(wpp_pkg::t_cfg_idx idx, logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v;
        sb.set_reg(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_wall(logic [15:0] ax, logic [15:0] ay, logic [15:0] bx,
                             logic [15:0] by, logic [15:0] fh, logic [14:0] wh, bit rev);
        // idle cycles, each taken with a fixed chance
        while (!steady && $urandom_range(0, 99) < 14) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_end_a_x <= ax; i_end_a_y <= ay; i_end_b_x <= bx; i_end_b_y <= by;
        i_floor_height <= fh; i_wall_height <= wh; i_reverse <= rev;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // walls mostly around the viewer so that clipping and projection get exercised
    task automatic send_random_wall();
        logic [15:0] c[4];
        logic [15:0] fh;
        logic [14:0] wh;
        bit near;
        near = $urandom_range(0, 99) < 75;
        for (int i = 0; i < 4; i++)
            c[i] = near ? 16'((i % 2 ? sb.vy : sb.vx) + $urandom_range(0, 3000) - 1500)
                        : 16'($urandom);
        fh = near ? 16'(sb.vz + $urandom_range(0, 400) - 200) : 16'($urandom);
        wh = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 300));
        send_wall(c[0], c[1], c[2], c[3], fh, wh, $urandom_range(0, 1));
    endtask

    task automatic load_view(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [8:0] a,
                             logic [7:0] p, logic [10:0] hw, logic [10:0] hh);
        write_reg(wpp_pkg::CFG_VIEWER_X, x);
        write_reg(wpp_pkg::CFG_VIEWER_Y, y);
        write_reg(wpp_pkg::CFG_VIEWER_Z, z);
        write_reg(wpp_pkg::CFG_VIEWER_ANGLE, 16'(a));
        write_reg(wpp_pkg::CFG_LOOK_PITCH, 16'(p));
        write_reg(wpp_pkg::CFG_HALF_WIDTH, 16'(hw));
        write_reg(wpp_pkg::CFG_HALF_HEIGHT, 16'(hh));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walls at reset view settings
        send_wall(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 15'd0, 1'b0);
        send_wall(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 15'h7fff, 1'b1);
        send_wall(-16'sd100, 16'sd200, 16'sd100, 16'sd200, -16'sd50, 15'd100, 1'b0);
        send_wall(-16'sd100, 16'sd200, 16'sd100, 16'sd200, -16'sd50, 15'd100, 1'b1);
        send_wall(-16'sd100, -16'sd20, 16'sd100, -16'sd5, 16'sd0, 15'd10, 1'b0);  // culled
        send_wall(-16'sd100, -16'sd50, 16'sd100, 16'sd300, 16'sd0, 15'd64, 1'b0); // clip a
        send_wall(-16'sd100, 16'sd300, 16'sd100, -16'sd50, 16'sd0, 15'd64, 1'b0); // clip b
        send_wall(16'sd0, 16'sd0, 16'sd50, 16'sd1, 16'sd10, 15'd20, 1'b0);  // depth to zero
        send_wall(16'sd30, 16'sd0, 16'sd30, 16'sd0, 16'sd0, 15'd5, 1'b0);   // degenerate wall
        send_wall(16'sd1, 16'sd1, -16'sd1, 16'sd1, 16'sd1, 15'd1, 1'b0);
        send_wall(16'h7fff, 16'sd2, 16'h8000, 16'sd2, 16'h7fff, 15'h7fff, 1'b0); // saturation
        send_wall(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 15'h7fff, 1'b1);
        drain();

        // extreme and random view settings, one batch of walls each
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: load_view(16'h7fff, 16'h7fff, 16'h7fff, 9'd90, 8'h7f, 11'd2047, 11'd2047);
                1: load_view(16'h8000, 16'h8000, 16'h8000, 9'd359, 8'h80, 11'd1, 11'd1);
                2: load_view(16'd0, 16'd0, 16'd0, 9'd511, 8'h00, 11'd0, 11'd0);
                3: load_view(16'd0, 16'd0, 16'd0, 9'd360, 8'h20, 11'd320, 11'd240);
                4: load_view(16'd0, 16'd0, 16'd0, 9'd180, 8'hf0, 11'd640, 11'd360);
                default: load_view(16'($urandom), 16'($urandom),
                                   16'($urandom_range(0, 4000) - 2000),
                                   9'($urandom_range(0, 511)), 8'($urandom),
                                   11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
            endcase
            steady = (ph == 4);
            repeat (ph == 0 ? 60 : 130) send_random_wall();
            drain();
        end
        steady = 1'b0;

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS wall_perspective_projector_unit");
        end else begin
            $display("FAIL wall_perspective_projector_unit");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("FAIL wall_perspective_projector_unit");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/wpp_pkg.sv
src/wpp_div.sv
src/wall_perspective_projector_unit.sv
sim/tb_wall_perspective_projector_unit.sv
